@@ design/ckc_pkg.sv @@
// Shared types, constants and helper functions of the canonical k-mer counter.
package ckc_pkg;

  localparam int unsigned CODE_BITS     = 30;
  localparam int unsigned UNIT_BASES    = CODE_BITS / 2;
  localparam int unsigned ADDR_BITS     = 24;
  localparam int unsigned IDX_BITS      = 16;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QUEUE_PW      = 2;

  localparam logic [3:0] RUN_MAX = 4'd15;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_KMER_LEN      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PREFIX_LEN    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PREFIX_VALUE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_CLAMP   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REPORT_ENABLE = 3'd5;

  // command codes
  localparam logic [1:0] CMD_BASE  = 2'd0;
  localparam logic [1:0] CMD_DRAIN = 2'd1;
  localparam logic [1:0] CMD_BIN   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // lower-case ASCII letters; bit 5 folds upper case onto them
  localparam logic [7:0] CH_CASE_BIT = 8'h20;
  localparam logic [7:0] CH_A        = 8'h61;
  localparam logic [7:0] CH_C        = 8'h63;
  localparam logic [7:0] CH_G        = 8'h67;
  localparam logic [7:0] CH_T        = 8'h74;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_DRAIN,
    OP_BIN,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 two;   // add two instead of one
    logic [ADDR_BITS-1:0] addr;  // table entry or histogram bin
    logic [CODE_BITS-1:0] code;  // full unit code of a drained entry
  } op_entry_t;

  typedef struct packed {
    logic [3:0]           kmer_len;
    logic [3:0]           prefix_len;
    logic [CODE_BITS-1:0] prefix_value;
    logic [31:0]          count_floor;
    logic [9:0]           count_clamp;
    logic                 report_enable;
  } cfg_t;

  typedef enum logic [2:0] {
    B_CLR_TAB,
    B_CLR_HIST,
    B_IDLE,
    B_CNT,
    B_DRN,
    B_DRN_HIST,
    B_BIN,
    B_OUT
  } b_state_t;

  // ones in the low 2*bases bits
  function automatic logic [CODE_BITS-1:0] low_mask(input logic [3:0] bases);
    low_mask = ~({CODE_BITS{1'b1}} << {bases, 1'b0});
  endfunction

  // reverse complement of the low 'bases' bases (bits above must be zero)
  function automatic logic [CODE_BITS-1:0] revcomp(input logic [CODE_BITS-1:0] code,
                                                   input logic [3:0] bases);
    logic [CODE_BITS-1:0] full;
    logic [3:0]           gap;
    for (int i = 0; i < UNIT_BASES; i++) begin
      full[2*(UNIT_BASES-1-i) +: 2] = ~code[2*i +: 2];
    end
    gap     = 4'(UNIT_BASES) - bases;
    revcomp = full >> {gap, 1'b0};
  endfunction

  // {valid, 2-bit base code}
  function automatic logic [2:0] base_decode(input logic [7:0] ch);
    logic [7:0] lc;
    lc = ch | CH_CASE_BIT;
    unique case (lc)
      CH_A:    base_decode = 3'b100;
      CH_C:    base_decode = 3'b101;
      CH_G:    base_decode = 3'b110;
      CH_T:    base_decode = 3'b111;
      default: base_decode = 3'b000;
    endcase
  endfunction

endpackage

@@ design/ckc_queue.sv @@
// Short operation queue between the classifying front and the table back end.
module ckc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ckc_pkg::op_entry_t  push_data,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output ckc_pkg::op_entry_t  head
);

  ckc_pkg::op_entry_t             slots [ckc_pkg::QUEUE_DEPTH];
  logic [ckc_pkg::QUEUE_PW:0]     fill;
  logic [ckc_pkg::QUEUE_PW-1:0]   wr_ptr;
  logic [ckc_pkg::QUEUE_PW-1:0]   rd_ptr;

  assign valid = fill != '0;
  assign full  = 32'(fill) == ckc_pkg::QUEUE_DEPTH;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push || pop)
    else $error("queue written while full");

endmodule

@@ design/ckc_front.sv @@
// Front end: takes items, rolls the k-mer, picks the canonical unit, queues work.
module ckc_front #(
  parameter int unsigned SUFFIX_BASES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  ckc_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [7:0]          character,
  input  logic [15:0]         index,
  input  logic                init_busy,
  input  logic                q_full,
  output logic                push,
  output ckc_pkg::op_entry_t  push_data
);

  localparam int unsigned TABLE_AW = 2 * SUFFIX_BASES;

  logic [ckc_pkg::CODE_BITS-1:0] kmer_shift, kmer_next;
  logic [3:0]                    valid_run;
  logic                          accept;
  logic [3:0]                    us, pl, sl;
  logic [ckc_pkg::CODE_BITS-1:0] umask, smask;
  logic [2:0]                    bd;
  logic                          counting;
  logic [TABLE_AW-1:0]           drain_addr;
  logic [ckc_pkg::CODE_BITS-1:0] drain_ext, drain_code, drain_full;
  logic [ckc_pkg::CODE_BITS-1:0] rc_in, rc_out, canon, canon_suffix;
  logic                          u_le_r, r_le_u, prefix_hit;

  assign in_ready = !q_full && !init_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    us           = (cfg.kmer_len == 4'd0) ? 4'd1 : cfg.kmer_len;
    umask        = ckc_pkg::low_mask(us);
    pl           = (cfg.prefix_len > us) ? us : cfg.prefix_len;
    sl           = us - pl;
    smask        = ckc_pkg::low_mask(sl);
    bd           = ckc_pkg::base_decode(character);
    kmer_next    = ((kmer_shift << 2) & umask) | {{(ckc_pkg::CODE_BITS-2){1'b0}}, bd[1:0]};
    counting     = valid_run >= (us - 4'd1);
    drain_addr   = TABLE_AW'(index);
    drain_ext    = '0;
    drain_ext[TABLE_AW-1:0] = drain_addr;
    drain_code   = cfg.prefix_value + drain_ext;
    drain_full   = drain_code & umask;
    // one reverse-complement unit serves the base and the drain path
    rc_in        = (cmd == ckc_pkg::CMD_BASE) ? kmer_next : drain_full;
    rc_out       = ckc_pkg::revcomp(rc_in, us);
    u_le_r       = kmer_next <= rc_out;
    r_le_u       = rc_out <= kmer_next;
    canon        = u_le_r ? kmer_next : rc_out;
    canon_suffix = canon & smask;
    prefix_hit   = (canon & umask & ~smask) == cfg.prefix_value;
  end

  always_comb begin
    push_data      = '0;
    push_data.code = drain_code;
    unique case (cmd)
      ckc_pkg::CMD_BASE: begin
        push_data.op                 = ckc_pkg::OP_COUNT;
        push_data.two                = u_le_r && r_le_u;   // palindrome counts twice
        push_data.addr[TABLE_AW-1:0] = canon_suffix[TABLE_AW-1:0];
      end
      ckc_pkg::CMD_DRAIN: begin
        push_data.op                 = ckc_pkg::OP_DRAIN;
        push_data.two                = drain_full != rc_out;
        push_data.addr[TABLE_AW-1:0] = drain_addr;
      end
      ckc_pkg::CMD_BIN: begin
        push_data.op                 = ckc_pkg::OP_BIN;
        push_data.addr[ckc_pkg::IDX_BITS-1:0] = index;
      end
      default: begin
        push_data.op                 = ckc_pkg::OP_CLEAR;
      end
    endcase
    push = accept && ((cmd != ckc_pkg::CMD_BASE) || (bd[2] && counting && prefix_hit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_shift <= '0;
      valid_run  <= '0;
    end else if (accept && cmd == ckc_pkg::CMD_BASE) begin
      if (!bd[2]) begin
        kmer_shift <= '0;
        valid_run  <= '0;
      end else begin
        kmer_shift <= kmer_next;
        if (valid_run != ckc_pkg::RUN_MAX) valid_run <= valid_run + 4'd1;
      end
    end
  end

endmodule

@@ design/ckc_back.sv @@
// Back end: count table and histogram memories, drain, bin read and clearing sweeps.
module ckc_back #(
  parameter int unsigned SUFFIX_BASES = 8,
  parameter int unsigned HIST_DEPTH   = 512,
  parameter int unsigned COUNT_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  ckc_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  ckc_pkg::op_entry_t  q_data,
  output logic                q_pop,
  output logic                init_busy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [29:0]         unit_code,
  output logic [31:0]         unit_count,
  output logic                entry_report,
  output logic [31:0]         bin_value,
  output logic [31:0]         total_units
);

  localparam int unsigned TABLE_AW    = 2 * SUFFIX_BASES;
  localparam int unsigned TABLE_DEPTH = 1 << TABLE_AW;
  localparam int unsigned HIST_AW     = $clog2(HIST_DEPTH);
  localparam int unsigned CLR_W       = (TABLE_AW > HIST_AW) ? TABLE_AW : HIST_AW;
  localparam logic [CLR_W-1:0] TAB_LAST  = CLR_W'(TABLE_DEPTH - 1);
  localparam logic [CLR_W-1:0] HIST_LAST = CLR_W'(HIST_DEPTH - 1);

  ckc_pkg::b_state_t state, state_next;

  logic [COUNT_BITS-1:0] tab_mem [TABLE_DEPTH];
  logic [31:0]           hist_mem [HIST_DEPTH];

  logic                  tab_we, tab_re, hist_we, hist_re;
  logic [TABLE_AW-1:0]   tab_waddr, tab_raddr;
  logic [COUNT_BITS-1:0] tab_wdata, tab_rdata;
  logic [HIST_AW-1:0]    hist_waddr, hist_raddr;
  logic [31:0]           hist_wdata, hist_rdata;

  logic [CLR_W-1:0]      clr_cnt;
  ckc_pkg::op_entry_t    op;
  logic [COUNT_BITS-1:0] cnt;
  logic                  rpt;
  logic [HIST_AW-1:0]    bin_addr;
  logic [31:0]           bin_val;
  logic [31:0]           unit_total;
  logic                  load_out, clr_start, q_bin_ok, op_bin_ok;

  logic [COUNT_BITS:0]   cnt_sum;
  logic [32:0]           hist_sum, total_sum;
  logic [31:0]           c32, minc, maxc, drn_bin32;
  logic                  ge_min;
  logic [HIST_AW-1:0]    drn_bin;

  always_comb begin
    c32       = 32'(tab_rdata);
    minc      = (cfg.count_floor == 32'd0) ? 32'd1 : cfg.count_floor;
    if (cfg.count_clamp == 10'd0)               maxc = 32'd1;
    else if (32'(cfg.count_clamp) > HIST_DEPTH) maxc = 32'(HIST_DEPTH);
    else                                        maxc = 32'(cfg.count_clamp);
    ge_min    = c32 >= minc;
    drn_bin32 = (c32 >= maxc) ? maxc - 32'd1 : c32 - 32'd1;
    drn_bin   = drn_bin32[HIST_AW-1:0];
    cnt_sum   = {1'b0, tab_rdata} + {{(COUNT_BITS-1){1'b0}}, op.two, !op.two};
    hist_sum  = {1'b0, hist_rdata} + {31'd0, op.two, !op.two};
    total_sum = {1'b0, unit_total} + {31'd0, op.two, !op.two};
    q_bin_ok  = 32'(q_data.addr) < HIST_DEPTH;
    op_bin_ok = 32'(op.addr) < HIST_DEPTH;
    clr_start = state == ckc_pkg::B_IDLE && q_valid && q_data.op == ckc_pkg::OP_CLEAR;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ckc_pkg::B_CLR_TAB:  if (clr_cnt == TAB_LAST)  state_next = ckc_pkg::B_CLR_HIST;
      ckc_pkg::B_CLR_HIST: if (clr_cnt == HIST_LAST) state_next = ckc_pkg::B_IDLE;
      ckc_pkg::B_IDLE: begin
        if (q_valid) begin
          unique case (q_data.op)
            ckc_pkg::OP_COUNT: state_next = ckc_pkg::B_CNT;
            ckc_pkg::OP_DRAIN: state_next = ckc_pkg::B_DRN;
            ckc_pkg::OP_BIN:   state_next = ckc_pkg::B_BIN;
            default:           state_next = ckc_pkg::B_CLR_HIST;
          endcase
        end
      end
      ckc_pkg::B_CNT:      state_next = ckc_pkg::B_IDLE;
      ckc_pkg::B_DRN:      state_next = ge_min ? ckc_pkg::B_DRN_HIST : ckc_pkg::B_OUT;
      ckc_pkg::B_DRN_HIST: state_next = ckc_pkg::B_OUT;
      ckc_pkg::B_BIN:      state_next = ckc_pkg::B_OUT;
      ckc_pkg::B_OUT:      if (!out_valid || out_ready) state_next = ckc_pkg::B_IDLE;
      default:             state_next = ckc_pkg::B_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    q_pop      = 1'b0;
    load_out   = 1'b0;
    tab_we     = 1'b0;
    tab_re     = 1'b0;
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    tab_waddr  = op.addr[TABLE_AW-1:0];
    tab_wdata  = '0;
    tab_raddr  = q_data.addr[TABLE_AW-1:0];
    hist_waddr = bin_addr;
    hist_wdata = '0;
    hist_raddr = q_data.addr[HIST_AW-1:0];
    unique case (state)
      ckc_pkg::B_CLR_TAB: begin
        tab_we    = 1'b1;
        tab_waddr = clr_cnt[TABLE_AW-1:0];
      end
      ckc_pkg::B_CLR_HIST: begin
        hist_we    = 1'b1;
        hist_waddr = clr_cnt[HIST_AW-1:0];
      end
      ckc_pkg::B_IDLE: begin
        q_pop   = q_valid;
        tab_re  = q_valid && (q_data.op == ckc_pkg::OP_COUNT || q_data.op == ckc_pkg::OP_DRAIN);
        hist_re = q_valid && q_data.op == ckc_pkg::OP_BIN && q_bin_ok;
      end
      ckc_pkg::B_CNT: begin
        tab_we    = 1'b1;
        tab_wdata = cnt_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : cnt_sum[COUNT_BITS-1:0];
      end
      ckc_pkg::B_DRN: begin
        tab_we     = 1'b1;           // drained entry is cleared
        hist_re    = ge_min;
        hist_raddr = drn_bin;
      end
      ckc_pkg::B_DRN_HIST: begin
        hist_we    = 1'b1;
        hist_wdata = hist_sum[32] ? 32'hFFFF_FFFF : hist_sum[31:0];
      end
      ckc_pkg::B_BIN: begin
      end
      ckc_pkg::B_OUT: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    if (tab_re) tab_rdata <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (hist_re) hist_rdata <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ckc_pkg::B_CLR_TAB;
      clr_cnt    <= '0;
      init_busy  <= 1'b1;
      unit_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next == ckc_pkg::B_CLR_HIST && state != ckc_pkg::B_CLR_HIST) begin
        clr_cnt <= '0;
      end else if (state == ckc_pkg::B_CLR_TAB || state == ckc_pkg::B_CLR_HIST) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state_next == ckc_pkg::B_IDLE) init_busy <= 1'b0;
      if (clr_start) begin
        unit_total <= '0;
      end else if (state == ckc_pkg::B_DRN && tab_rdata != '0) begin
        unit_total <= total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
      end
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) op <= q_data;
    if (state == ckc_pkg::B_DRN) begin
      cnt      <= tab_rdata;
      rpt      <= ge_min && cfg.report_enable;
      bin_addr <= drn_bin;
    end
    if (state == ckc_pkg::B_BIN) bin_val <= op_bin_ok ? hist_rdata : 32'd0;
    if (load_out) begin
      if (op.op == ckc_pkg::OP_DRAIN) begin
        unit_code    <= op.code;
        unit_count   <= 32'(cnt);
        entry_report <= rpt;
        bin_value    <= 32'd0;
      end else begin
        unit_code    <= '0;
        unit_count   <= 32'd0;
        entry_report <= 1'b0;
        bin_value    <= bin_val;
      end
      total_units <= unit_total;
    end
  end

  a_out_loaded: assert property (@(posedge clk) disable iff (rst) load_out |=> out_valid)
    else $error("result not presented after load");

  a_bin_range: assert property (@(posedge clk) disable iff (rst)
      hist_we |-> 32'(hist_waddr) < HIST_DEPTH)
    else $error("histogram write outside the bins");

  a_total_grows: assert property (@(posedge clk) disable iff (rst)
      !$past(rst) && !$past(clr_start) |-> unit_total >= $past(unit_total))
    else $error("unit total dropped without a clear");

endmodule

@@ design/canonical_kmer_counter.sv @@
// Result path on an idle block: a bin read passes B_BIN then B_OUT; a drain passes B_DRN,
// then B_DRN_HIST when its count reaches the minimum, then B_OUT, before out_valid rises.
// Throughput: items enter a 4-deep queue at one per cycle while in_ready is high; the back end
// then takes one queued operation at a time through its states: a counted base, bin read or drain
// by read-modify-write on the table and histogram memories, a statistics clear by a bin sweep.
// Reset: a sweep zeroes the table, then the histogram memory; in_ready stays low meanwhile.
module canonical_kmer_counter #(
  parameter int unsigned SUFFIX_BASES = 8,
  parameter int unsigned HIST_DEPTH   = 512,
  parameter int unsigned COUNT_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  character,
  input  logic [15:0] index,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] unit_code,
  output logic [31:0] unit_count,
  output logic        entry_report,
  output logic [31:0] bin_value,
  output logic [31:0] total_units
);

  ckc_pkg::cfg_t      cfg;
  logic               init_busy;
  logic               q_full, q_valid, q_pop, push;
  ckc_pkg::op_entry_t push_data, q_head;

  // Configuration registers. User rule, not enforced: only written while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kmer_len      <= 4'd8;
      cfg.prefix_len    <= 4'd0;
      cfg.prefix_value  <= '0;
      cfg.count_floor   <= 32'd1;
      cfg.count_clamp   <= 10'd500;
      cfg.report_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ckc_pkg::CFG_KMER_LEN:      cfg.kmer_len      <= cfg_data[3:0];
        ckc_pkg::CFG_PREFIX_LEN:    cfg.prefix_len    <= cfg_data[3:0];
        ckc_pkg::CFG_PREFIX_VALUE:  cfg.prefix_value  <= cfg_data[29:0];
        ckc_pkg::CFG_COUNT_FLOOR:   cfg.count_floor   <= cfg_data;
        ckc_pkg::CFG_COUNT_CLAMP:   cfg.count_clamp   <= cfg_data[9:0];
        ckc_pkg::CFG_REPORT_ENABLE: cfg.report_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Front: rolling k-mer, reverse complement, canonical pick and prefix filter.
  // Bases that start no count (ambiguous, short run, prefix miss) never reach the queue.
  ckc_front #(
    .SUFFIX_BASES (SUFFIX_BASES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .character (character),
    .index     (index),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Queue of classified operations; lets front and back stall independently.
  ckc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Back: table increments, drains with histogram update, bin reads, clears,
  // and the output register that holds a result until it is taken.
  ckc_back #(
    .SUFFIX_BASES (SUFFIX_BASES),
    .HIST_DEPTH   (HIST_DEPTH),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .init_busy    (init_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .unit_code    (unit_code),
    .unit_count   (unit_count),
    .entry_report (entry_report),
    .bin_value    (bin_value),
    .total_units  (total_units)
  );

endmodule
